>>> rtl/core/tppc_pkg.sv
// shared constants, register codes and crc-8 function for the thermal packet pec checker
package tppc_pkg;

	// register indexes, selected by paddr[2]
	localparam logic REG_PKT_BYTES = 1'b0;
	localparam logic REG_RD_ADDR   = 1'b1;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [5:0] PKT_BYTES_RST = 6'd35;
	localparam logic [5:0] MIN_PKT_BYTES = 6'd3;
	localparam logic [7:0] RD_ADDR_RST   = 8'h15;
	localparam logic [7:0] CRC_POLY      = 8'h07;

	// one byte through crc-8, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] v);
		logic [7:0] c;
		c = v;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	localparam logic [7:0] SEED_RST = crc8_byte(RD_ADDR_RST);

endpackage

>>> rtl/core/thermal_packet_pec_checker.sv
// Thermal packet PEC checker: takes one packet byte per word on the input channel, runs an
// SMBus-style CRC-8 (poly 0x07) seeded with the CRC of the read-address byte, emits each little-endian
// 16-bit reading when its high byte arrives and a final word with pec_ok at the PEC byte. Each
// byte passes an input register and the CRC logic into the result register; a new byte is
// accepted every cycle, and throughput drops only while out_ready is held low with a result
// word pending. Low bytes and out-of-pair bytes give no result word.
// Registers: packet_bytes at 0x0 (reset 35, values below 3 act as 3), read_address_byte at 0x4
// (reset 0x15, used at the next packet's first byte).
module thermal_packet_pec_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tppc_pkg::PADDR_W-1:0]      paddr,
	input  logic [tppc_pkg::PDATA_W-1:0]      pwdata,
	output logic [tppc_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              packet_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [15:0]                       reading,
	output logic [4:0]                        reading_index,
	output logic                              is_final,
	output logic                              pec_ok
);

	logic [5:0] pkt_bytes_q;
	logic [7:0] rd_addr_q;
	logic [7:0] seed_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	logic [5:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] hold_q;

	logic        out_valid_q;
	logic [15:0] reading_q;
	logic [4:0]  index_q;
	logic        final_q;
	logic        pec_ok_q;

	logic       advance;
	logic       cfg_wr;
	logic       restart;
	logic [5:0] pos_eff;
	logic [7:0] crc_eff;
	logic [5:0] last_pos;
	logic       at_pec;
	logic [7:0] crc_next;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign advance = ~out_valid_q | out_ready;
	assign in_ready = ~valid_s1 | advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_bytes_q <= tppc_pkg::PKT_BYTES_RST;
			rd_addr_q   <= tppc_pkg::RD_ADDR_RST;
			seed_q      <= tppc_pkg::SEED_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tppc_pkg::REG_PKT_BYTES: pkt_bytes_q <= pwdata[5:0];
				tppc_pkg::REG_RD_ADDR: begin
					rd_addr_q <= pwdata[7:0];
					seed_q    <= tppc_pkg::crc8_byte(pwdata[7:0]);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tppc_pkg::REG_PKT_BYTES: prdata = {{(tppc_pkg::PDATA_W-6){1'b0}}, pkt_bytes_q};
			tppc_pkg::REG_RD_ADDR:   prdata = {{(tppc_pkg::PDATA_W-8){1'b0}}, rd_addr_q};
			default:                 prdata = '0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			start_s1 <= packet_start;
		end
	end

	// position zero always reseeds the crc
	always_comb begin
		restart  = start_s1 | (pos_q == 6'd0);
		pos_eff  = restart ? 6'd0 : pos_q;
		crc_eff  = restart ? seed_q : crc_q;
		last_pos = ((pkt_bytes_q < tppc_pkg::MIN_PKT_BYTES) ?
			tppc_pkg::MIN_PKT_BYTES : pkt_bytes_q) - 6'd1;
		at_pec   = pos_eff >= last_pos;
		crc_next = tppc_pkg::crc8_byte(crc_eff ^ byte_s1);
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= '0;
			hold_q <= '0;
		end else if (valid_s1 && advance) begin
			if (at_pec) begin
				pos_q <= '0;
				crc_q <= crc_eff;
			end else begin
				pos_q <= pos_eff + 6'd1;
				crc_q <= crc_next;
				if (!pos_eff[0]) begin
					hold_q <= byte_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 & (at_pec | pos_eff[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (at_pec) begin
				reading_q <= '0;
				index_q   <= '0;
				final_q   <= 1'b1;
				pec_ok_q  <= (crc_eff == byte_s1);
			end else begin
				reading_q <= {byte_s1, hold_q};
				index_q   <= pos_eff[5:1];
				final_q   <= 1'b0;
				pec_ok_q  <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign reading       = reading_q;
	assign reading_index = index_q;
	assign is_final      = final_q;
	assign pec_ok        = pec_ok_q;

endmodule

>>> rtl/core/tppc_port_chk.sv
// port-level checks for the thermal packet pec checker, bound to the top level
module tppc_port_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] reading,
	input logic [4:0]  reading_index,
	input logic        is_final,
	input logic        pec_ok
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(reading_index)
			&& $stable(is_final) && $stable(pec_ok))
		else $error("result word changed while stalled");

	a_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_final |-> reading == 16'd0 && reading_index == 5'd0)
		else $error("final word carries a reading");

	a_pec_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_final |-> !pec_ok)
		else $error("pec_ok set on a reading word");

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind thermal_packet_pec_checker tppc_port_chk u_tppc_port_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.reading       (reading),
	.reading_index (reading_index),
	.is_final      (is_final),
	.pec_ok        (pec_ok)
);
